[hw/rtl/spq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg : shared types and codes for the stable priority queue
// Command and status codes, datapath operation codes and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int WORD_W   = 32;

	// input commands
	localparam logic [1:0] CMD_ENQ  = 2'd0;
	localparam logic [1:0] CMD_DEQ  = 2'd1;
	localparam logic [1:0] CMD_DISP = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	// result status
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	typedef enum logic [1:0] {
		DP_HOLD,
		DP_INSERT,
		DP_REMOVE,
		DP_ROTATE
	} dp_op_t;

	typedef struct packed {
		dp_op_t      op;
		logic        disp_start;
		logic        load;
		logic [1:0]  status;
		logic        front;
		logic        last;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic disp_final;
	} dp_stat_t;

endpackage : spq_pkg
`default_nettype wire

[hw/rtl/stable_priority_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_queue : sorted priority queue, lowest rank first
// Top level: controller and datapath with the interface checks.
// ----------------------------------------------------------------------------
// Holds up to Capacity entries kept in ascending signed rank, equal ranks in
// arrival order. Enqueue and dequeue each work in a row of entry cells that
// compare and shift in parallel, and give one result (ok, overflow or
// underflow). Display streams every entry front to back, one transfer per
// cycle while the output is not stalled, by rotating the ring of occupied
// cells through the front cell (a single result with status empty when there
// are none); no command is taken meanwhile. A single output register sits
// between the sides, so a new command is taken while a result waits as long
// as the output stage can be refilled. Command code three is dropped without
// a result. No clearing pass is needed after reset.
module stable_priority_queue #(
	parameter int Capacity = spq_pkg::CAPACITY
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic signed [31:0] item_value,
	input  wire logic signed [31:0] item_rank,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              status,
	output logic signed [31:0]      out_value,
	output logic signed [31:0]      out_rank,
	output logic                    last
);
	import spq_pkg::*;

	dp_cmd_t  ctl;
	dp_stat_t stat;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl),
		.stat      (stat)
	);

	spq_dp #(
		.Capacity (Capacity)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.item_value (item_value),
		.item_rank  (item_rank),
		.status     (status),
		.out_value  (out_value),
		.out_rank   (out_rank),
		.last       (last)
	);

	// error and empty results always close their command
	a_status_last : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> last)
		else $error("non-ok result without last");

	// enqueue and dequeue deliver their result in the next cycle
	a_single_result : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && ((cmd == CMD_ENQ) || (cmd == CMD_DEQ))
		|=> out_valid && last)
		else $error("enqueue or dequeue result missing");

	// a display of an empty store gives the empty status and closes the command
	a_empty_display : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (cmd == CMD_DISP) && stat.empty
		|=> out_valid && (status == ST_EMPTY) && last)
		else $error("empty display result missing");

	a_full_not_empty : assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !stat.empty)
		else $error("store flagged full and empty");

endmodule : stable_priority_queue
`default_nettype wire

[hw/rtl/spq_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl : queue controller
// Decodes accepted commands, sequences the display stream and owns the
// output valid flag and both handshakes.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       cmd,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output spq_pkg::dp_cmd_t      ctl,
	input  wire spq_pkg::dp_stat_t stat
);
	import spq_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_DISP = 1'b1;

	logic    state_q;
	logic    state_d;
	logic    out_valid_q;
	logic    can_load;
	logic    accept;

	assign can_load  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE) || !can_load;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		ctl        = '0;
		ctl.op     = DP_HOLD;
		ctl.status = ST_OK;
		state_d    = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd)
						CMD_ENQ: begin
							ctl.load = 1'b1;
							ctl.last = 1'b1;
							if (stat.full) begin
								ctl.status = ST_OVERFLOW;
							end else begin
								ctl.op = DP_INSERT;
							end
						end
						CMD_DEQ: begin
							ctl.load = 1'b1;
							ctl.last = 1'b1;
							if (stat.empty) begin
								ctl.status = ST_UNDERFLOW;
							end else begin
								ctl.op    = DP_REMOVE;
								ctl.front = 1'b1;
							end
						end
						CMD_DISP: begin
							if (stat.empty) begin
								ctl.load   = 1'b1;
								ctl.last   = 1'b1;
								ctl.status = ST_EMPTY;
							end else begin
								ctl.disp_start = 1'b1;
								state_d        = S_DISP;
							end
						end
						default: begin
							// unused code: drop the command
						end
					endcase
				end
			end
			S_DISP: begin
				// one entry per transfer, rotating the store back to its order
				if (can_load) begin
					ctl.op    = DP_ROTATE;
					ctl.load  = 1'b1;
					ctl.front = 1'b1;
					ctl.last  = stat.disp_final;
					if (stat.disp_final) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule : spq_ctrl
`default_nettype wire

[hw/rtl/spq_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spq_dp : queue datapath
// A row of sorted entry cells that insert, shift out or rotate in parallel,
// the occupancy and display counters, and the output register.
// ----------------------------------------------------------------------------
module spq_dp #(
	parameter int Capacity = spq_pkg::CAPACITY
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire spq_pkg::dp_cmd_t           ctl,
	output spq_pkg::dp_stat_t               stat,
	input  wire logic signed [31:0]         item_value,
	input  wire logic signed [31:0]         item_rank,
	output logic [1:0]                      status,
	output logic signed [31:0]              out_value,
	output logic signed [31:0]              out_rank,
	output logic                            last
);
	import spq_pkg::*;

	localparam int OccW = $clog2(Capacity + 1);

	logic signed [WORD_W-1:0] val_q  [Capacity];
	logic signed [WORD_W-1:0] rank_q [Capacity];
	logic [OccW-1:0]          occ_q;
	logic [OccW-1:0]          left_q;
	logic [Capacity-1:0]      gt;

	logic [1:0]               status_q;
	logic signed [WORD_W-1:0] value_q;
	logic signed [WORD_W-1:0] orank_q;
	logic                     last_q;

	for (genvar g = 0; g < Capacity; g++) begin : g_cell
		logic signed [WORD_W-1:0] up_v;
		logic signed [WORD_W-1:0] up_r;
		logic signed [WORD_W-1:0] dn_v;
		logic signed [WORD_W-1:0] dn_r;
		logic                     in_use;
		logic                     first_gt;

		// empty slots count as holding a higher rank
		assign in_use = OccW'(g) < occ_q;
		assign gt[g]  = !in_use || (item_rank < rank_q[g]);

		if (g == 0) begin : g_head
			assign up_v     = item_value;
			assign up_r     = item_rank;
			assign first_gt = gt[g];
		end else begin : g_body
			assign up_v     = val_q[g-1];
			assign up_r     = rank_q[g-1];
			assign first_gt = gt[g] && !gt[g-1];
		end

		// neighbour behind, or the front entry when this is the tail of the ring
		if (g == Capacity - 1) begin : g_tail
			assign dn_v = val_q[0];
			assign dn_r = rank_q[0];
		end else begin : g_mid
			assign dn_v = (OccW'(g + 1) >= occ_q) ? val_q[0]  : val_q[g+1];
			assign dn_r = (OccW'(g + 1) >= occ_q) ? rank_q[0] : rank_q[g+1];
		end

		always_ff @(posedge clk) begin
			case (ctl.op)
				DP_INSERT: begin
					if (gt[g]) begin
						val_q[g]  <= first_gt ? item_value : up_v;
						rank_q[g] <= first_gt ? item_rank  : up_r;
					end
				end
				DP_REMOVE, DP_ROTATE: begin
					val_q[g]  <= dn_v;
					rank_q[g] <= dn_r;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			left_q <= '0;
		end else begin
			if (ctl.op == DP_INSERT) begin
				occ_q <= occ_q + OccW'(1);
			end else if (ctl.op == DP_REMOVE) begin
				occ_q <= occ_q - OccW'(1);
			end
			if (ctl.disp_start) begin
				left_q <= occ_q;
			end else if (ctl.op == DP_ROTATE) begin
				left_q <= left_q - OccW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			status_q <= ctl.status;
			value_q  <= ctl.front ? val_q[0]  : '0;
			orank_q  <= ctl.front ? rank_q[0] : '0;
			last_q   <= ctl.last;
		end
	end

	assign stat.empty      = (occ_q == '0);
	assign stat.full       = (occ_q == OccW'(Capacity));
	assign stat.disp_final = (left_q == OccW'(1));

	assign status    = status_q;
	assign out_value = value_q;
	assign out_rank  = orank_q;
	assign last      = last_q;

endmodule : spq_dp
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb : testbench for the stable priority queue
// Drives enqueue, dequeue, display and the unused command into the queue,
// keeps its own sorted copy of the store to work out every expected result,
// and compares each output transfer field by field, in order, with random
// idle bursts on both sides.
// ----------------------------------------------------------------------------
module tb;
	import spq_pkg::*;

	localparam int DEPTH       = spq_pkg::CAPACITY;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE      = 8;

	typedef struct {
		logic [1:0]         status;
		logic signed [31:0] value;
		logic signed [31:0] rank;
		logic               last;
	} result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b1;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         cmd = CMD_NONE;
	logic signed [31:0] item_value = '0;
	logic signed [31:0] item_rank = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic signed [31:0] out_value;
	logic signed [31:0] out_rank;
	logic               last;

	// own copy of the sorted store
	logic signed [31:0] held_value [DEPTH];
	logic signed [31:0] held_rank [DEPTH];
	int                 held_count = 0;
	result_t            pending_results [$];

	int mismatch_count = 0;
	int quiet_cycles = 0;
	int stall_left = 0;
	bit idle_on = 1'b0;

	stable_priority_queue #(.Capacity(DEPTH)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.item_value (item_value),
		.item_rank  (item_rank),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.out_value  (out_value),
		.out_rank   (out_rank),
		.last       (last)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] MISMATCH %s", $realtime, what);
	endtask

	function automatic void push_result(input logic [1:0] st, input logic signed [31:0] v,
			input logic signed [31:0] r, input logic l);
		result_t res;
		res.status = st;
		res.value  = v;
		res.rank   = r;
		res.last   = l;
		pending_results.push_back(res);
	endfunction

	// Apply one accepted command to the local store and queue its results.
	function automatic void apply_command(input logic [1:0] c, input logic signed [31:0] v,
			input logic signed [31:0] r);
		int pos;
		case (c)
			CMD_ENQ: begin
				if (held_count >= DEPTH) begin
					push_result(ST_OVERFLOW, '0, '0, 1'b1);
				end else begin
					// insert behind every entry of lower or equal rank
					pos = 0;
					while (pos < held_count && !(r < held_rank[pos]))
						pos++;
					for (int i = held_count; i > pos; i--) begin
						held_value[i] = held_value[i-1];
						held_rank[i]  = held_rank[i-1];
					end
					held_value[pos] = v;
					held_rank[pos]  = r;
					held_count++;
					push_result(ST_OK, '0, '0, 1'b1);
				end
			end
			CMD_DEQ: begin
				if (held_count == 0) begin
					push_result(ST_UNDERFLOW, '0, '0, 1'b1);
				end else begin
					push_result(ST_OK, held_value[0], held_rank[0], 1'b1);
					for (int i = 1; i < held_count; i++) begin
						held_value[i-1] = held_value[i];
						held_rank[i-1]  = held_rank[i];
					end
					held_count--;
				end
			end
			CMD_DISP: begin
				if (held_count == 0)
					push_result(ST_EMPTY, '0, '0, 1'b1);
				else
					for (int i = 0; i < held_count; i++)
						push_result(ST_OK, held_value[i], held_rank[i], i == held_count - 1);
			end
			default: ;
		endcase
	endfunction

	// Present one command and hold it until the transfer.
	task automatic send_command(input logic [1:0] c, input logic signed [31:0] v,
			input logic signed [31:0] r);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid   = 1'b0;
			item_value = $urandom;
			item_rank  = $urandom;
			repeat (gap) @(negedge clk);
		end
		in_valid   = 1'b1;
		cmd        = c;
		item_value = v;
		item_rank  = r;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		apply_command(c, v, r);
	endtask

	// Drop valid and wait until every expected result has arrived.
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// output side: random stall bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else if (idle_on && arst_n && $urandom_range(0, 3) == 0) begin
			out_stall  = 1'b1;
			stall_left = $urandom_range(0, 2);
		end else begin
			out_stall = 1'b0;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
				if (out_value !== want.value)
					report_mismatch($sformatf("out_value %h, expected %h", out_value, want.value));
				if (out_rank !== want.rank)
					report_mismatch($sformatf("out_rank %h, expected %h", out_rank, want.rank));
				if (last !== want.last)
					report_mismatch($sformatf("last %b, expected %b", last, want.last));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic test_empty_queue();
		send_command(CMD_DEQ, 32'sd5, 32'sd6);
		send_command(CMD_DISP, -32'sd1, -32'sd1);
		send_command(CMD_NONE, 32'h5555_aaaa, 32'haaaa_5555);
		drain_results();
	endtask

	task automatic test_rank_order();
		send_command(CMD_ENQ, 32'hffff_ffff, 32'h7fff_ffff);
		send_command(CMD_ENQ, 32'h8000_0000, 32'h8000_0000);
		send_command(CMD_ENQ, 32'h0000_0000, 32'h0000_0000);
		send_command(CMD_ENQ, 32'h7fff_ffff, 32'hffff_ffff);
		// equal ranks must come out in arrival order
		send_command(CMD_ENQ, 32'sd1, 32'sd0);
		send_command(CMD_ENQ, 32'sd2, 32'sd0);
		send_command(CMD_DISP, '0, '0);
		send_command(CMD_DEQ, '0, '0);
		drain_results();
	endtask

	task automatic test_full_queue();
		while (held_count < DEPTH)
			send_command(CMD_ENQ, $urandom, $urandom_range(0, 3));
		send_command(CMD_ENQ, 32'h1234_5678, 32'sd0);
		send_command(CMD_DISP, '0, '0);
		drain_results();
	endtask

	task automatic test_random_traffic();
		int                 pick;
		int                 enq_pct;
		logic [1:0]         c;
		logic signed [31:0] r;
		for (int seg = 0; seg < 8; seg++) begin
			// quiet stretch in the third segment; no idling in the final part
			idle_on = (seg < 6) && (seg != 2);
			enq_pct = (seg % 3 == 0) ? 65 : (seg % 3 == 1) ? 25 : 45;
			for (int n = 0; n < 37; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < enq_pct)
					c = CMD_ENQ;
				else if (pick < enq_pct + 10)
					c = CMD_DISP;
				else if (pick < enq_pct + 13)
					c = CMD_NONE;
				else
					c = CMD_DEQ;
				case ($urandom_range(0, 3))
					0: r = $urandom;
					1: r = $signed($urandom_range(0, 6)) - 3;
					2: case ($urandom_range(0, 3))
						0: r = 32'h8000_0000;
						1: r = 32'h7fff_ffff;
						2: r = 32'h0000_0000;
						default: r = 32'hffff_ffff;
					endcase
					default: r = $urandom_range(0, 15);
				endcase
				send_command(c, $urandom, r);
			end
		end
		drain_results();
	endtask

	initial begin
		// assert reset a little after time zero so the edge is seen
		#1 arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		idle_on = 1'b1;
		test_empty_queue();
		test_rank_order();
		test_full_queue();
		test_random_traffic();
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
